// ----- sv/eased_animation_channel_table_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the animation channel table
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef EASED_ANIMATION_CHANNEL_TABLE_TOP_ASSERT_SVH
`define EASED_ANIMATION_CHANNEL_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define EAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/eac_pkg.sv -----
// ---------------------------------------------------------------------------
// eac_pkg
// Shared types, codes and constants of the animation channel table.
// ---------------------------------------------------------------------------
package eac_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 48;

  // operation codes
  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_NOTIFY   = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_KILL     = 3'd3;
  localparam logic [2:0] OP_KILL_ALL = 3'd4;
  localparam logic [2:0] OP_QUERY    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // easing curves
  localparam logic [3:0] CRV_LINEAR       = 4'd0;
  localparam logic [3:0] CRV_IN_QUAD      = 4'd1;
  localparam logic [3:0] CRV_OUT_QUAD     = 4'd2;
  localparam logic [3:0] CRV_INOUT_QUAD   = 4'd3;
  localparam logic [3:0] CRV_OUT_CUBIC    = 4'd4;
  localparam logic [3:0] CRV_INOUT_CUBIC  = 4'd5;
  localparam logic [3:0] CRV_OUT_ELASTIC  = 4'd6;
  localparam logic [3:0] CRV_OUT_BOUNCE   = 4'd7;
  localparam logic [3:0] CRV_IN_BACK      = 4'd8;
  localparam logic [3:0] CRV_OUT_BACK     = 4'd9;

  // Q16 arithmetic constants
  localparam longint ONE     = 65536;
  localparam longint HALF    = 32768;
  localparam longint BACK_C  = 111515;
  localparam longint BACK_C1 = 177051;
  localparam longint LN2_Q16 = 45426;
  localparam longint RECIP3  = 1398102;  // ceil(2^22 / 3)
  localparam longint PHASE_OFS = 147456;
  localparam longint SIN_K0  = 64'sd11290046313;
  localparam longint SIN_K1  = 64'sd20590572507;
  localparam longint SIN_K2  = 64'sd21905742302;
  localparam longint SIN_K3  = 64'sd11097578693;
  localparam longint SIN_K4  = 64'sd1686629713;

  // 2^(-k/16) in Q16
  function automatic logic [16:0] exp2_tab(input logic [3:0] k);
    logic [16:0] r;
    unique case (k)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd62757;
      4'd2:  r = 17'd60097;
      4'd3:  r = 17'd57549;
      4'd4:  r = 17'd55109;
      4'd5:  r = 17'd52773;
      4'd6:  r = 17'd50535;
      4'd7:  r = 17'd48393;
      4'd8:  r = 17'd46341;
      4'd9:  r = 17'd44376;
      4'd10: r = 17'd42495;
      4'd11: r = 17'd40693;
      4'd12: r = 17'd38968;
      4'd13: r = 17'd37316;
      4'd14: r = 17'd35734;
      default: r = 17'd34219;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [31:0]        el;
    logic [31:0]        dur;
    logic [3:0]         curve;
    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
  } eac_math_req_t;

  typedef struct packed {
    logic               running;
    logic               notify;
    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
    logic [31:0]        dur;
    logic [31:0]        elapsed;
    logic [3:0]         curve;
    logic               link_v;
    logic [5:0]         link;
  } eac_word_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
    logic [31:0]        run_time;
    logic [3:0]         curve;
    logic               chained;
    logic [5:0]         chain_slot;
    logic [31:0]        time_step;
  } eac_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         channel;
    logic signed [31:0] value;
    logic               done;
    logic               ntf;
    logic               full;
    logic               act;
  } eac_res_t;

endpackage

// ----- sv/eac_ram.sv -----
// ---------------------------------------------------------------------------
// eac_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module eac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/eac_math.sv -----
// ---------------------------------------------------------------------------
// eac_math
// Progress divider, easing sequencer and interpolation on one multiplier.
// ---------------------------------------------------------------------------
module eac_math (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  eac_pkg::eac_math_req_t req,
  output logic                  busy,
  output logic                  done,
  output logic signed [31:0]    value
);

  typedef enum logic [1:0] {M_IDLE, M_DIV, M_EASE, M_FIN} mstate_t;

  mstate_t            st_r;
  logic [4:0]         cnt_r;
  logic [31:0]        rem_r;
  logic [31:0]        dur_r;
  logic [15:0]        q_r;
  logic [3:0]         curve_r;
  logic signed [31:0] start_r;
  logic signed [32:0] d_r;
  logic signed [39:0] r0_r, r1_r, r2_r, acc_r;
  logic signed [23:0] e_r;
  logic               done_r;
  logic signed [31:0] value_r;

  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [36:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [60:0] prod;
  logic signed [39:0] r0_nxt, r1_nxt, r2_nxt, acc_nxt;
  logic signed [23:0] e_nxt;
  logic signed [31:0] value_nxt;
  logic               ease_last;

  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, dur_r};

  always_comb begin
    logic signed [63:0] t, f, e10, b11, d, p, fm, m, x, v;
    logic [15:0]        fp, r;
    logic [3:0]         ip;
    t   = {48'd0, q_r};
    f   = t - eac_pkg::ONE;
    e10 = 10 * t;
    b11 = 11 * t;
    fp  = e10[15:0];
    ip  = e10[19:16];
    r   = r0_r[15:0];
    if (r < 16'd16384) begin
      x = {48'd0, r};
    end else if (r < 16'd49152) begin
      x = 64'sd32768 - {48'd0, r};
    end else begin
      x = {48'd0, r} - 64'sd65536;
    end
    if (b11 < 4 * eac_pkg::ONE) begin
      d = b11;
    end else if (b11 < 8 * eac_pkg::ONE) begin
      d = b11 - 6 * eac_pkg::ONE;
    end else if (b11 < 10 * eac_pkg::ONE) begin
      d = b11 - 9 * eac_pkg::ONE;
    end else begin
      d = 22 * t - 21 * eac_pkg::ONE;
    end

    // operand select
    mul_a = '0;
    mul_b = '0;
    if (st_r == M_FIN) begin
      mul_a = 37'(d_r);
      mul_b = e_r;
    end else begin
      unique case (curve_r)
        eac_pkg::CRV_IN_QUAD: begin
          mul_a = 37'(t); mul_b = 24'(t);
        end
        eac_pkg::CRV_OUT_QUAD: begin
          mul_a = 37'(t); mul_b = 24'(2 * eac_pkg::ONE - t);
        end
        eac_pkg::CRV_INOUT_QUAD: begin
          if (t < eac_pkg::HALF) begin
            mul_a = 37'(t);
          end else begin
            mul_a = 37'(4 * eac_pkg::ONE - 2 * t);
          end
          mul_b = 24'(t);
        end
        eac_pkg::CRV_OUT_CUBIC: begin
          mul_a = (cnt_r == 5'd0) ? 37'(f) : 37'(r0_r);
          mul_b = 24'(f);
        end
        eac_pkg::CRV_INOUT_CUBIC: begin
          if (t < eac_pkg::HALF) begin
            mul_a = (cnt_r == 5'd0) ? 37'(t) : 37'(r0_r);
            mul_b = 24'(t);
          end else begin
            mul_a = (cnt_r == 5'd0) ? 37'(f) : 37'(r0_r);
            mul_b = 24'(2 * t - 2 * eac_pkg::ONE);
          end
        end
        eac_pkg::CRV_OUT_ELASTIC: begin
          unique case (cnt_r)
            5'd0: begin mul_a = 37'({52'd0, fp[11:0]}); mul_b = 24'(eac_pkg::LN2_Q16); end
            5'd1: begin mul_a = 37'(r0_r); mul_b = 24'(r0_r); end
            5'd2: begin mul_a = 37'({47'd0, eac_pkg::exp2_tab(fp[15:12])}); mul_b = 24'(r1_r); end
            5'd3: begin mul_a = 37'(e10 + eac_pkg::PHASE_OFS); mul_b = 24'(eac_pkg::RECIP3); end
            5'd4: begin mul_a = 37'(x); mul_b = 24'(x); end
            5'd5: begin mul_a = 37'(eac_pkg::SIN_K0); mul_b = 24'(r1_r); end
            5'd6, 5'd7, 5'd8: begin mul_a = 37'(acc_r); mul_b = 24'(r1_r); end
            5'd9: begin mul_a = 37'(acc_r); mul_b = 24'(r0_r); end
            default: begin mul_a = 37'(r2_r); mul_b = 24'(r1_r); end
          endcase
        end
        eac_pkg::CRV_OUT_BOUNCE: begin
          mul_a = 37'(d); mul_b = 24'(d);
        end
        eac_pkg::CRV_IN_BACK: begin
          unique case (cnt_r)
            5'd0:    begin mul_a = 37'(t); mul_b = 24'(t); end
            5'd1:    begin mul_a = 37'(eac_pkg::BACK_C1); mul_b = 24'(t); end
            default: begin mul_a = 37'(r0_r); mul_b = 24'(r1_r); end
          endcase
        end
        eac_pkg::CRV_OUT_BACK: begin
          unique case (cnt_r)
            5'd0:    begin mul_a = 37'(f); mul_b = 24'(f); end
            5'd1:    begin mul_a = 37'(eac_pkg::BACK_C1); mul_b = 24'(f); end
            default: begin mul_a = 37'(r0_r); mul_b = 24'(r1_r); end
          endcase
        end
        default: begin
          mul_a = '0; mul_b = '0;
        end
      endcase
    end

    prod = mul_a * mul_b;
    p    = 64'(prod);
    fm   = (p + eac_pkg::HALF) >>> 16;

    // post-processing of the step
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    acc_nxt   = acc_r;
    e_nxt     = e_r;
    ease_last = 1'b0;
    m         = (p + eac_pkg::HALF) >>> 16;
    unique case (curve_r)
      eac_pkg::CRV_IN_QUAD, eac_pkg::CRV_OUT_QUAD: begin
        e_nxt = 24'(fm); ease_last = 1'b1;
      end
      eac_pkg::CRV_INOUT_QUAD: begin
        e_nxt = (t < eac_pkg::HALF) ? 24'(2 * fm) : 24'(fm - eac_pkg::ONE);
        ease_last = 1'b1;
      end
      eac_pkg::CRV_OUT_CUBIC: begin
        if (cnt_r == 5'd0) begin
          r0_nxt = 40'(fm);
        end else begin
          e_nxt = 24'(fm + eac_pkg::ONE); ease_last = 1'b1;
        end
      end
      eac_pkg::CRV_INOUT_CUBIC: begin
        if (cnt_r == 5'd0) begin
          r0_nxt = 40'(fm);
        end else begin
          e_nxt = (t < eac_pkg::HALF) ? 24'(4 * fm) : 24'(fm + eac_pkg::ONE);
          ease_last = 1'b1;
        end
      end
      eac_pkg::CRV_OUT_ELASTIC: begin
        unique case (cnt_r)
          5'd0: r0_nxt = 40'(p >>> 16);
          5'd1: r1_nxt = 40'(eac_pkg::ONE - 64'(r0_r) + (p >>> 17));
          5'd2: r2_nxt = 40'(m >>> ip);
          5'd3: r0_nxt = 40'(p >>> 22);
          5'd4: begin r0_nxt = 40'(x); r1_nxt = 40'(p >>> 8); end
          5'd5: acc_nxt = 40'(eac_pkg::SIN_K1 - (p >>> 24));
          5'd6: acc_nxt = 40'(eac_pkg::SIN_K2 - (p >>> 24));
          5'd7: acc_nxt = 40'(eac_pkg::SIN_K3 - (p >>> 24));
          5'd8: acc_nxt = 40'(eac_pkg::SIN_K4 - (p >>> 24));
          5'd9: r1_nxt = 40'(p >>> 28);
          default: begin
            e_nxt = 24'(fm + eac_pkg::ONE); ease_last = 1'b1;
          end
        endcase
      end
      eac_pkg::CRV_OUT_BOUNCE: begin
        if (b11 < 4 * eac_pkg::ONE) begin
          e_nxt = 24'((p + 64'sd524288) >>> 20);
        end else if (b11 < 8 * eac_pkg::ONE) begin
          e_nxt = 24'(((p + 64'sd524288) >>> 20) + 64'sd49152);
        end else if (b11 < 10 * eac_pkg::ONE) begin
          e_nxt = 24'(((p + 64'sd524288) >>> 20) + 64'sd61440);
        end else begin
          e_nxt = 24'(((p + 64'sd2097152) >>> 22) + 64'sd64512);
        end
        ease_last = 1'b1;
      end
      eac_pkg::CRV_IN_BACK: begin
        unique case (cnt_r)
          5'd0:    r0_nxt = 40'(fm);
          5'd1:    r1_nxt = 40'(fm - eac_pkg::BACK_C);
          default: begin e_nxt = 24'(fm); ease_last = 1'b1; end
        endcase
      end
      eac_pkg::CRV_OUT_BACK: begin
        unique case (cnt_r)
          5'd0:    r0_nxt = 40'(fm);
          5'd1:    r1_nxt = 40'(fm + eac_pkg::BACK_C);
          default: begin e_nxt = 24'(fm + eac_pkg::ONE); ease_last = 1'b1; end
        endcase
      end
      default: begin
        e_nxt = 24'(t); ease_last = 1'b1;
      end
    endcase
    // zero progress eases to zero on every curve
    if (q_r == 16'd0) begin
      e_nxt     = '0;
      ease_last = 1'b1;
    end

    v = 64'(start_r) + fm;
    if (v > 64'sd2147483647) begin
      value_nxt = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      value_nxt = 32'sh80000000;
    end else begin
      value_nxt = 32'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (req_valid) begin
            rem_r   <= req.el;
            dur_r   <= req.dur;
            q_r     <= '0;
            curve_r <= req.curve;
            start_r <= req.start_v;
            d_r     <= 33'(req.end_v) - 33'(req.start_v);
            cnt_r   <= '0;
            st_r    <= M_DIV;
          end
        end
        M_DIV: begin
          // one quotient bit per cycle
          rem_r <= rem_ge ? 32'(rem_sh - {1'b0, dur_r}) : rem_sh[31:0];
          q_r   <= {q_r[14:0], rem_ge};
          if (cnt_r == 5'd15) begin
            cnt_r <= '0;
            st_r  <= M_EASE;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        M_EASE: begin
          r0_r  <= r0_nxt;
          r1_r  <= r1_nxt;
          r2_r  <= r2_nxt;
          acc_r <= acc_nxt;
          e_r   <= e_nxt;
          if (ease_last) begin
            cnt_r <= '0;
            st_r  <= M_FIN;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        default: begin
          value_r <= value_nxt;
          done_r  <= 1'b1;
          st_r    <= M_IDLE;
        end
      endcase
    end
  end

  assign busy  = (st_r != M_IDLE);
  assign done  = done_r;
  assign value = value_r;

endmodule

// ----- sv/eased_animation_channel_table_top.sv -----
// ---------------------------------------------------------------------------
// eased_animation_channel_table_top
// Table of animation channels tweening Q16.16 values with easing curves.
// ---------------------------------------------------------------------------
// Usage: items enter on the in_ stream (in_tuser = op code), results leave
// on the out_ stream (out_tuser = result kind, out_tlast = final result of
// the item). One item is worked on at a time; in_tready is high only while
// the block waits for an item.
// Create scans the active flags one slot a cycle and answers with the slot
// it takes, or with full. Query answers; set notify, kill and kill all give
// no result. A tick walks all SLOTS entries: an inactive slot is skipped,
// a waiting slot is read and passed over, a finishing slot answers with its
// end value, and a slot in flight runs through the bit-serial divider and
// the ease steps (1 to 11, elastic the longest) on the shared multiplier in
// eac_math.
// Results of a tick are held one deep so the last one can carry tlast.
// Reset clears the flags and the state; the channel memory is not cleared and
// needs no clearing pass. A stalled receiver holds the output register and
// the walk waits on it, so nothing is dropped.
// ---------------------------------------------------------------------------
`include "eased_animation_channel_table_top_assert.svh"

module eased_animation_channel_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[5:0] start_value[37:6] end_value[69:38] run_time[101:70]
  // curve[105:102] chained[106] chain_slot[112:107] time_step[144:113]
  input  logic [151:0] in_tdata,
  // op[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // channel[5:0] value[37:6] done_res[38] notify[39] full_res[40]
  // is_active[41]
  output logic [47:0]  out_tdata,
  // kind[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  localparam int SW = eac_pkg::SLOT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CSCAN, ST_NWB, ST_TCHECK, ST_TREAD, ST_TMATH, ST_TEMIT, ST_FLUSH
  } state_t;

  state_t                  state_r;
  logic [SW:0]             idx_r;
  logic [eac_pkg::SLOTS-1:0] active_r;
  eac_pkg::eac_item_t      item_r;
  eac_pkg::eac_res_t       res_r, hold_r, out_r;
  logic                    hold_v_r;
  logic                    out_valid_r;
  logic                    out_last_r;

  eac_pkg::eac_item_t      in_item;
  eac_pkg::eac_word_t      rd_word, wr_word;
  logic                    ram_we;
  logic [SW-1:0]           ram_waddr, ram_raddr;
  logic [SW-1:0]           slot_idx;
  logic                    scan_end;
  logic                    in_acc;
  logic                    in_slot_ok;
  logic                    lk_free, runnable, fin;
  logic [32:0]             el_sum;
  logic [31:0]             el_sat;
  logic                    out_free;
  logic                    tick_finish;

  eac_pkg::eac_math_req_t  math_req;
  logic                    math_start, math_busy, math_done;
  logic signed [31:0]      math_value;

  // unpack the input transfer
  assign in_item.slot       = in_tdata[5:0];
  assign in_item.start_v    = in_tdata[37:6];
  assign in_item.end_v      = in_tdata[69:38];
  assign in_item.run_time   = in_tdata[101:70];
  assign in_item.curve      = in_tdata[105:102];
  assign in_item.chained    = in_tdata[106];
  assign in_item.chain_slot = in_tdata[112:107];
  assign in_item.time_step  = in_tdata[144:113];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_slot_ok = {1'b0, in_item.slot} < 7'(eac_pkg::SLOTS);

  assign slot_idx = idx_r[SW-1:0];
  assign scan_end = (idx_r == (SW+1)'(eac_pkg::SLOTS));
  assign out_free = !out_valid_r || out_tready;

  // slot evaluation on the word read back for the tick walk
  assign lk_free  = ({1'b0, rd_word.link} >= 7'(eac_pkg::SLOTS)) ||
                    !active_r[rd_word.link[SW-1:0]];
  assign runnable = rd_word.running || (rd_word.link_v && lk_free);
  assign el_sum   = {1'b0, rd_word.elapsed} + {1'b0, item_r.time_step};
  assign el_sat   = el_sum[32] ? 32'hffffffff : el_sum[31:0];
  assign fin      = el_sat >= rd_word.dur;
  assign tick_finish = (state_r == ST_TREAD) && runnable && fin;

  assign math_start       = (state_r == ST_TREAD) && runnable && !fin;
  assign math_req.el      = el_sat;
  assign math_req.dur     = rd_word.dur;
  assign math_req.curve   = rd_word.curve;
  assign math_req.start_v = rd_word.start_v;
  assign math_req.end_v   = rd_word.end_v;

  // read the addressed slot while idle (set notify), else the walk slot
  assign ram_raddr = (state_r == ST_IDLE) ? in_item.slot[SW-1:0] : slot_idx;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx;
    wr_word   = rd_word;
    unique case (state_r)
      ST_CSCAN: begin
        if (!scan_end && !active_r[slot_idx]) begin
          ram_we          = 1'b1;
          wr_word.running = !item_r.chained;
          wr_word.notify  = 1'b0;
          wr_word.start_v = item_r.start_v;
          wr_word.end_v   = item_r.end_v;
          wr_word.dur     = item_r.run_time;
          wr_word.elapsed = '0;
          wr_word.curve   = item_r.curve;
          wr_word.link_v  = item_r.chained;
          wr_word.link    = item_r.chained ? item_r.chain_slot : 6'd0;
        end
      end
      ST_NWB: begin
        ram_we         = 1'b1;
        ram_waddr      = item_r.slot[SW-1:0];
        wr_word.notify = 1'b1;
      end
      ST_TREAD: begin
        if (runnable) begin
          ram_we          = 1'b1;
          wr_word.running = 1'b1;
          wr_word.elapsed = el_sat;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  eac_ram #(
    .WIDTH($bits(eac_pkg::eac_word_t)),
    .DEPTH(eac_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_word),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  eac_math u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (math_start),
    .req       (math_req),
    .busy      (math_busy),
    .done      (math_done),
    .value     (math_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      active_r    <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // retire the output transfer; a new load below overrides
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            item_r <= in_item;
            idx_r  <= '0;
            unique case (in_tuser)
              eac_pkg::OP_CREATE: state_r <= ST_CSCAN;
              eac_pkg::OP_NOTIFY: begin
                if (in_slot_ok && active_r[in_item.slot[SW-1:0]]) begin
                  state_r <= ST_NWB;
                end
              end
              eac_pkg::OP_TICK: state_r <= ST_TCHECK;
              eac_pkg::OP_KILL: begin
                if (in_slot_ok) begin
                  active_r[in_item.slot[SW-1:0]] <= 1'b0;
                end
              end
              eac_pkg::OP_KILL_ALL: active_r <= '0;
              eac_pkg::OP_QUERY: begin
                hold_r   <= '{kind: eac_pkg::KIND_QUERY, channel: in_item.slot,
                              value: '0, done: 1'b0, ntf: 1'b0, full: 1'b0,
                              act: in_slot_ok && active_r[in_item.slot[SW-1:0]]};
                hold_v_r <= 1'b1;
                state_r  <= ST_FLUSH;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_CSCAN: begin
          if (scan_end) begin
            hold_r   <= '{kind: eac_pkg::KIND_CREATE, channel: 6'd0, value: '0,
                          done: 1'b0, ntf: 1'b0, full: 1'b1, act: 1'b0};
            hold_v_r <= 1'b1;
            state_r  <= ST_FLUSH;
          end else if (!active_r[slot_idx]) begin
            active_r[slot_idx] <= 1'b1;
            hold_r   <= '{kind: eac_pkg::KIND_CREATE, channel: 6'(slot_idx),
                          value: '0, done: 1'b0, ntf: 1'b0, full: 1'b0, act: 1'b0};
            hold_v_r <= 1'b1;
            state_r  <= ST_FLUSH;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_NWB: state_r <= ST_IDLE;
        ST_TCHECK: begin
          if (scan_end) begin
            state_r <= ST_FLUSH;
          end else if (!active_r[slot_idx]) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            state_r <= ST_TREAD;
          end
        end
        ST_TREAD: begin
          if (!runnable) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_TCHECK;
          end else if (fin) begin
            active_r[slot_idx] <= 1'b0;
            res_r   <= '{kind: eac_pkg::KIND_UPDATE, channel: 6'(slot_idx),
                         value: rd_word.end_v, done: 1'b1, ntf: rd_word.notify,
                         full: 1'b0, act: 1'b0};
            state_r <= ST_TEMIT;
          end else begin
            state_r <= ST_TMATH;
          end
        end
        ST_TMATH: begin
          if (math_done) begin
            res_r   <= '{kind: eac_pkg::KIND_UPDATE, channel: 6'(slot_idx),
                         value: math_value, done: 1'b0, ntf: 1'b0,
                         full: 1'b0, act: 1'b0};
            state_r <= ST_TEMIT;
          end
        end
        ST_TEMIT: begin
          // keep one result back so the final one can carry tlast
          if (!hold_v_r) begin
            hold_r   <= res_r;
            hold_v_r <= 1'b1;
            idx_r    <= idx_r + 1'b1;
            state_r  <= ST_TCHECK;
          end else if (out_free) begin
            out_r       <= hold_r;
            out_last_r  <= 1'b0;
            out_valid_r <= 1'b1;
            hold_r      <= res_r;
            idx_r       <= idx_r + 1'b1;
            state_r     <= ST_TCHECK;
          end
        end
        default: begin
          // flush the held result as the last of the item
          if (!hold_v_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_r       <= hold_r;
            out_last_r  <= 1'b1;
            out_valid_r <= 1'b1;
            hold_v_r    <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.act, out_r.full, out_r.ntf, out_r.done,
                       out_r.value, out_r.channel};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;

  `EAC_ASSERT_IMP(a_math_only_in_tick, math_busy, state_r == ST_TMATH,
                  "math unit busy outside a tick step")
  `EAC_ASSERT_NXT(a_create_marks_slot,
                  state_r == ST_CSCAN && !scan_end && !active_r[slot_idx],
                  active_r[$past(slot_idx)], "created slot not marked active")
  `EAC_ASSERT_NXT(a_finish_frees_slot, tick_finish,
                  !active_r[$past(slot_idx)], "finished slot still active")

endmodule

// ----- sim/eased_animation_channel_table_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Animation channel table testbench
// Drives op items on the in_ stream and checks every out_ transfer against
// an internal model of the channel table. It covers create, notify, tick,
// kill, kill all and query, chained channels, a full table and all curves.
// ---------------------------------------------------------------------------
module eased_animation_channel_table_top_tb;

  localparam longint LN_DIV = 64'sd25769803776;

  // one expected result transfer
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  channel;
    logic [31:0] value;
    logic        done;
    logic        ntf;
    logic        full;
    logic        act;
    logic        last;
  } anim_res_t;

  // one input item
  typedef struct {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [31:0] start_v;
    logic [31:0] end_v;
    logic [31:0] run_time;
    logic [3:0]  curve;
    logic        chained;
    logic [5:0]  chain_slot;
    logic [31:0] time_step;
  } anim_item_t;

  // floor shift for signed values
  function automatic longint fl_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fl_shr(a * b + eac_pkg::HALF, 16);
  endfunction

  function automatic longint sine_q16(logic [31:0] ph);
    longint r, x, x2, acc;
    r = ph[15:0];
    if (r < 16384) x = r;
    else if (r < 49152) x = 32768 - r;
    else x = r - 65536;
    x2 = (x * x) >>> 8;
    acc = eac_pkg::SIN_K0;
    acc = eac_pkg::SIN_K1 - fl_shr(x2 * acc, 24);
    acc = eac_pkg::SIN_K2 - fl_shr(x2 * acc, 24);
    acc = eac_pkg::SIN_K3 - fl_shr(x2 * acc, 24);
    acc = eac_pkg::SIN_K4 - fl_shr(x2 * acc, 24);
    return fl_shr(x * acc, 28);
  endfunction

  function automatic longint pow2_neg(longint e);
    longint ip, fp, g, y, p, m;
    longint tab[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                        46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
    ip = e >>> 16;
    fp = e & 64'hFFFF;
    g = fp & 64'hFFF;
    y = (g * eac_pkg::LN2_Q16) >>> 16;
    p = eac_pkg::ONE - y + ((y * y) >>> 17) - (y * y * y) / LN_DIV;
    m = (tab[(fp >>> 12) & 15] * p + 32768) >>> 16;
    if (ip >= 32) return 0;
    return m >>> ip;
  endfunction

  function automatic longint curve_at(logic [3:0] c, longint t);
    longint f, d;
    if (t <= 0) return 0;
    case (c)
      eac_pkg::CRV_IN_QUAD:  return qmul(t, t);
      eac_pkg::CRV_OUT_QUAD: return qmul(t, 2 * eac_pkg::ONE - t);
      eac_pkg::CRV_INOUT_QUAD: begin
        if (t < eac_pkg::ONE / 2) return 2 * qmul(t, t);
        return -eac_pkg::ONE + qmul(4 * eac_pkg::ONE - 2 * t, t);
      end
      eac_pkg::CRV_OUT_CUBIC: begin
        f = t - eac_pkg::ONE;
        return qmul(qmul(f, f), f) + eac_pkg::ONE;
      end
      eac_pkg::CRV_INOUT_CUBIC: begin
        if (t < eac_pkg::ONE / 2) return 4 * qmul(qmul(t, t), t);
        f = 2 * t - 2 * eac_pkg::ONE;
        return qmul(qmul(t - eac_pkg::ONE, f), f) + eac_pkg::ONE;
      end
      eac_pkg::CRV_OUT_ELASTIC: begin
        f = (10 * t - 49152 + 196608) / 3;
        return qmul(pow2_neg(10 * t), sine_q16(f[31:0])) + eac_pkg::ONE;
      end
      eac_pkg::CRV_OUT_BOUNCE: begin
        if (11 * t < 4 * eac_pkg::ONE) begin
          d = 11 * t;
          return (d * d + (1 << 19)) >>> 20;
        end
        if (11 * t < 8 * eac_pkg::ONE) begin
          d = 11 * t - 6 * eac_pkg::ONE;
          return ((d * d + (1 << 19)) >>> 20) + 49152;
        end
        if (11 * t < 10 * eac_pkg::ONE) begin
          d = 11 * t - 9 * eac_pkg::ONE;
          return ((d * d + (1 << 19)) >>> 20) + 61440;
        end
        d = 22 * t - 21 * eac_pkg::ONE;
        return ((d * d + (1 << 21)) >>> 22) + 64512;
      end
      eac_pkg::CRV_IN_BACK:
        return qmul(qmul(t, t), qmul(eac_pkg::BACK_C1, t) - eac_pkg::BACK_C);
      eac_pkg::CRV_OUT_BACK: begin
        f = t - eac_pkg::ONE;
        return qmul(qmul(f, f), qmul(eac_pkg::BACK_C1, f) + eac_pkg::BACK_C)
               + eac_pkg::ONE;
      end
      default: return t;
    endcase
  endfunction

  // channel table model and the queue of pending results
  class channel_scoreboard;
    bit          active[eac_pkg::SLOTS];
    bit          running[eac_pkg::SLOTS];
    bit          ntf[eac_pkg::SLOTS];
    logic [31:0] sv[eac_pkg::SLOTS];
    logic [31:0] ev[eac_pkg::SLOTS];
    logic [31:0] dur[eac_pkg::SLOTS];
    logic [31:0] el[eac_pkg::SLOTS];
    logic [3:0]  crv[eac_pkg::SLOTS];
    bit          link_v[eac_pkg::SLOTS];
    logic [5:0]  link[eac_pkg::SLOTS];
    anim_res_t   pending[$];
    int          errors;

    function void push(logic [1:0] k, logic [5:0] ch, logic [31:0] v, bit d, bit n,
                       bit f, bit a);
      anim_res_t r;
      r.kind = k; r.channel = ch; r.value = v; r.done = d; r.ntf = n;
      r.full = f; r.act = a; r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function int free_count();
      int n;
      n = 0;
      foreach (active[i]) if (!active[i]) n++;
      return n;
    endfunction

    // note an accepted item and predict its results
    function void note_item(anim_item_t it);
      int i, n;
      longint e, t, d, v;
      logic [32:0] sum;
      case (it.op)
        eac_pkg::OP_CREATE: begin
          for (i = 0; i < eac_pkg::SLOTS; i++) if (!active[i]) break;
          if (i >= eac_pkg::SLOTS) push(eac_pkg::KIND_CREATE, 0, 0, 0, 0, 1, 0);
          else begin
            active[i] = 1; sv[i] = it.start_v; ev[i] = it.end_v;
            dur[i] = it.run_time; el[i] = 0; crv[i] = it.curve; ntf[i] = 0;
            running[i] = !it.chained; link_v[i] = it.chained;
            link[i] = it.chain_slot;
            push(eac_pkg::KIND_CREATE, 6'(i), 0, 0, 0, 0, 0);
          end
        end
        eac_pkg::OP_NOTIFY: if (active[it.slot]) ntf[it.slot] = 1;
        eac_pkg::OP_TICK: begin
          n = 0;
          for (i = 0; i < eac_pkg::SLOTS; i++) begin
            if (!active[i]) continue;
            if (!running[i]) begin
              if (link_v[i] && !active[link[i]]) running[i] = 1;
              else continue;
            end
            sum = {1'b0, el[i]} + {1'b0, it.time_step};
            el[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (el[i] >= dur[i]) begin
              active[i] = 0;
              push(eac_pkg::KIND_UPDATE, 6'(i), ev[i], 1, ntf[i], 0, 0);
            end else begin
              t = ({32'd0, el[i]} << 16) / {32'd0, dur[i]};
              e = curve_at(crv[i], t);
              d = longint'($signed(ev[i])) - longint'($signed(sv[i]));
              v = longint'($signed(sv[i])) + fl_shr(d * e + eac_pkg::HALF, 16);
              if (v > 64'sd2147483647) v = 64'sd2147483647;
              if (v < -64'sd2147483648) v = -64'sd2147483648;
              push(eac_pkg::KIND_UPDATE, 6'(i), v[31:0], 0, 0, 0, 0);
            end
            pending[$].last = 1'b0;
            n++;
          end
          if (n > 0) pending[$].last = 1'b1;
        end
        eac_pkg::OP_KILL: active[it.slot] = 0;
        eac_pkg::OP_KILL_ALL: foreach (active[j]) active[j] = 0;
        eac_pkg::OP_QUERY: push(eac_pkg::KIND_QUERY, it.slot, 0, 0, 0, 0, active[it.slot]);
        default: ;
      endcase
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(anim_res_t got);
      anim_res_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d ch=%0d value=%h", $time,
                 got.kind, got.channel, got.value);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got !== x) begin
        $display("%0t: mismatch expected kind=%0d ch=%0d val=%h d=%b n=%b f=%b a=%b l=%b",
                 $time, x.kind, x.channel, x.value, x.done, x.ntf, x.full, x.act, x.last);
        $display("%0t:          actual kind=%0d ch=%0d val=%h d=%b n=%b f=%b a=%b l=%b",
                 $time, got.kind, got.channel, got.value, got.done, got.ntf, got.full,
                 got.act, got.last);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  channel_scoreboard table_sb = new();
  bit  calm = 0;        // no idling in the final stretch
  bit  hold_rx = 0;     // long receiver hold-off in progress

  always #2 clk = ~clk;

  eased_animation_channel_table_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_rx = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 18);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Check each result transfer.
  always @(posedge clk) begin
    anim_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.channel = out_tdata[5:0];
      got.value = out_tdata[37:6];
      got.done = out_tdata[38];
      got.ntf = out_tdata[39];
      got.full = out_tdata[40];
      got.act = out_tdata[41];
      got.last = out_tlast;
      table_sb.check_result(got);
    end
  end

  // Offer one item, hold it until the transfer, then note it.
  task automatic send_item(anim_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {7'd0, it.time_step, it.chain_slot, it.chained, it.curve,
                  it.run_time, it.end_v, it.start_v, it.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_sb.note_item(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  function automatic anim_item_t mk_item(logic [2:0] op);
    anim_item_t it;
    it.op = op;
    it.slot = $urandom_range(0, 63);
    it.start_v = rand_word();
    it.end_v = rand_word();
    it.run_time = $urandom_range(0, 1) ? $urandom_range(0, 32'h0008_0000) : rand_word();
    it.curve = $urandom_range(0, 15);
    it.chained = ($urandom_range(0, 3) == 0);
    it.chain_slot = $urandom_range(0, 63);
    it.time_step = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 32'h0002_0000);
    return it;
  endfunction

  // Drop the offer and wait until every expected result has come.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (table_sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    anim_item_t it;
    int k, r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every curve, extremes, chain, notify, zero duration.
    for (k = 0; k < 11; k++) begin
      it = mk_item(eac_pkg::OP_CREATE);
      it.curve = (k == 10) ? 4'd15 : k[3:0];
      it.start_v = (k % 2) ? 32'h8000_0000 : 32'h0001_0000;
      it.end_v = (k % 2) ? 32'h7FFF_FFFF : 32'hFFFE_0000;
      it.run_time = (k == 0) ? 32'd0 : 32'h0001_0000;
      it.chained = (k == 3);
      it.chain_slot = (k == 3) ? 6'd1 : 6'd63;
      send_item(it);
    end
    it = mk_item(eac_pkg::OP_NOTIFY); it.slot = 1; send_item(it);
    it = mk_item(eac_pkg::OP_NOTIFY); it.slot = 63; send_item(it);
    it = mk_item(eac_pkg::OP_QUERY); it.slot = 2; send_item(it);
    it = mk_item(eac_pkg::OP_QUERY); it.slot = 63; send_item(it);
    for (k = 0; k < 4; k++) begin
      it = mk_item(eac_pkg::OP_TICK);
      it.time_step = (k == 3) ? 32'hFFFF_FFFF : 32'h0000_5555;
      send_item(it);
    end
    it = mk_item(eac_pkg::OP_KILL); it.slot = 5; send_item(it);
    it = mk_item(eac_pkg::OP_KILL_ALL); send_item(it);
    it = mk_item(3'd6); send_item(it);
    it = mk_item(3'd7); send_item(it);

    // Fill the table to overflow, with a long receiver hold-off meanwhile.
    hold_rx = 1;
    for (k = 0; k < eac_pkg::SLOTS + 2; k++) begin
      it = mk_item(eac_pkg::OP_CREATE);
      it.chained = 0;
      it.curve = $urandom_range(0, 9);
      send_item(it);
    end
    // Sender pauses until all results are in.
    drain();
    it = mk_item(eac_pkg::OP_TICK); it.time_step = 32'h0000_4000; send_item(it);
    it = mk_item(eac_pkg::OP_KILL_ALL); send_item(it);

    // Random part: mostly creates and ticks with some noise.
    for (k = 0; k < 30; k++) begin
      if (k == 22) calm = 1;
      r = $urandom_range(0, 99);
      if (r < 35 && table_sb.free_count() > 0) it = mk_item(eac_pkg::OP_CREATE);
      else if (r < 70) it = mk_item(eac_pkg::OP_TICK);
      else if (r < 78) it = mk_item(eac_pkg::OP_NOTIFY);
      else if (r < 86) it = mk_item(eac_pkg::OP_QUERY);
      else if (r < 94) it = mk_item(eac_pkg::OP_KILL);
      else if (r < 97) it = mk_item(eac_pkg::OP_KILL_ALL);
      else it = mk_item($urandom_range(6, 7));
      send_item(it);
    end
    drain();
    repeat (200) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
